FILE: rtl/core/fir_pkg.sv
// Package for the direct-form FIR filter: sizes, payload types and item codes.
// No dependencies. Every other file in rtl/core but fir_ram uses it by scoped names.
package fir_pkg;

    localparam int TAPS        = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_BITS    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int INDEX_BITS  = 6;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int ACC_BITS    = 2 * SAMPLE_BITS + TAP_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [TAP_BITS-1:0]           tap_addr_t;
    typedef logic [INDEX_BITS-1:0]         tap_index_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    // item kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // control that travels alongside one operand pair into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

FILE: rtl/core/fir_if.sv
// Channel interfaces for the FIR filter: sample/coefficient input and result output.
// Depends on fir_pkg for payload types.
interface fir_in_if;
    logic                valid;
    logic                ready;
    logic                kind;
    fir_pkg::sample_t    sample_in;
    fir_pkg::tap_index_t tap_index;
    fir_pkg::sample_t    tap_value;

    modport source (output valid, kind, sample_in, tap_index, tap_value, input ready);
    modport sink   (input valid, kind, sample_in, tap_index, tap_value, output ready);
endinterface

interface fir_out_if;
    logic             valid;
    logic             ready;
    fir_pkg::sample_t filtered_sample;

    modport source (output valid, filtered_sample, input ready);
    modport sink   (input valid, filtered_sample, output ready);
endinterface

FILE: rtl/core/fir_filter_direct_form.sv
// Top level of the 64-tap direct-form FIR filter: sequencer, delay-line and
// coefficient RAMs, shared MAC. Depends on fir_pkg, fir_if, fir_ram, fir_mac.
//
//  channel | dir | payload                                      | handshake
//  --------+-----+----------------------------------------------+-------------
//  in_ch   | in  | kind, sample_in, tap_index, tap_value         | valid/ready
//  out_ch  | out | filtered_sample                              | valid/ready
//
// Coefficient item: taken with no result; ready stays high.
// Sample item: the sequencer issues every tap to the single MAC in ST_RUN,
//   waits in ST_DRAIN for RAM read, product and accumulate, loads the output
//   register in ST_OUT and returns to ST_IDLE; no new item is taken before then.
// Reset (rst_n, async, low) zeroes the delay line via per-slot valid bits;
//   coefficients are undefined until written.
// A finished result waits in the output register; the next item is accepted
//   meanwhile, and the sequencer holds only if a new result finds it still full.
module fir_filter_direct_form (
    input  logic     clk,
    input  logic     rst_n,
    fir_in_if.sink   in_ch,
    fir_out_if.source out_ch
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    localparam fir_pkg::tap_addr_t LAST_TAP = fir_pkg::tap_addr_t'(fir_pkg::TAPS - 1);

    state_t             state_reg;
    fir_pkg::tap_addr_t k_reg;       // coefficient index being issued
    fir_pkg::tap_addr_t slot_reg;    // delay-line slot matching k_reg
    fir_pkg::tap_addr_t pos_reg;     // slot of newest sample
    logic [fir_pkg::TAPS-1:0] dvalid_reg;  // slot written since reset
    logic               out_valid_reg;
    fir_pkg::sample_t   out_data_reg;

    fir_pkg::mac_ctl_t  ctl_issue;
    fir_pkg::mac_ctl_t  ctl_q_reg;   // aligned with RAM read data
    logic               dvalid_q_reg;

    logic               in_acc;
    logic               push;
    logic               coef_we;
    fir_pkg::tap_addr_t pos_inc;
    fir_pkg::sample_t   coef_rd;
    fir_pkg::sample_t   delay_rd;
    fir_pkg::sample_t   delay_masked;
    logic               mac_done;
    fir_pkg::sample_t   mac_result;
    logic               out_free;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid & in_ch.ready;
    assign push        = in_acc & (in_ch.kind == fir_pkg::KIND_SAMPLE);
    // writes beyond the store are dropped
    assign coef_we     = in_acc & (in_ch.kind == fir_pkg::KIND_COEF)
                         & (int'(in_ch.tap_index) < fir_pkg::TAPS);
    assign pos_inc     = (pos_reg == LAST_TAP) ? '0 : pos_reg + 1'b1;
    assign out_free    = ~out_valid_reg | out_ch.ready;

    assign ctl_issue.valid = (state_reg == ST_RUN);
    assign ctl_issue.first = (k_reg == '0);
    assign ctl_issue.last  = (k_reg == LAST_TAP);

    fir_ram #(
        .WIDTH (fir_pkg::SAMPLE_BITS),
        .DEPTH (fir_pkg::TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (fir_pkg::tap_addr_t'(in_ch.tap_index)),
        .wdata (in_ch.tap_value),
        .raddr (k_reg),
        .rdata (coef_rd)
    );

    fir_ram #(
        .WIDTH (fir_pkg::SAMPLE_BITS),
        .DEPTH (fir_pkg::TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (push),
        .waddr (pos_inc),
        .wdata (in_ch.sample_in),
        .raddr (slot_reg),
        .rdata (delay_rd)
    );

    // unwritten delay slots read as zero
    assign delay_masked = dvalid_q_reg ? delay_rd : '0;

    fir_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_q_reg),
        .coef   (coef_rd),
        .data   (delay_masked),
        .done   (mac_done),
        .result (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            slot_reg      <= '0;
            pos_reg       <= '0;
            dvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            ctl_q_reg     <= '0;
            dvalid_q_reg  <= 1'b0;
        end
        else
        begin
            ctl_q_reg    <= ctl_issue;
            dvalid_q_reg <= dvalid_reg[slot_reg];

            // in ST_OUT a taken result is replaced below instead
            if (out_valid_reg && out_ch.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (push)
                    begin
                        pos_reg              <= pos_inc;
                        slot_reg             <= pos_inc;
                        dvalid_reg[pos_inc]  <= 1'b1;
                        k_reg                <= '0;
                        state_reg            <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    k_reg    <= k_reg + 1'b1;
                    slot_reg <= (slot_reg == '0) ? LAST_TAP : slot_reg - 1'b1;
                    if (k_reg == LAST_TAP)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (mac_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= mac_result;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.filtered_sample = out_data_reg;

    // MAC finishes only while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_DRAIN)
        else $error("MAC result outside drain phase");

    // last tap issued moves the sequencer to drain
    a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && k_reg == LAST_TAP) |=> state_reg == ST_DRAIN)
        else $error("sequencer did not leave run after last tap");

    // a taken result is not repeated unless a new one is loaded
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.ready && state_reg != ST_OUT) |=> !out_valid_reg)
        else $error("output item repeated");

endmodule

FILE: rtl/core/fir_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/fir_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate,
// then round-half-up and saturate. Depends on fir_pkg.
module fir_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  fir_pkg::mac_ctl_t ctl,
    input  fir_pkg::sample_t  coef,
    input  fir_pkg::sample_t  data,
    output logic              done,
    output fir_pkg::sample_t  result
);

    localparam fir_pkg::acc_t ROUND_HALF =
        fir_pkg::acc_t'(64'sd1 <<< (fir_pkg::FRAC_BITS - 1));
    localparam fir_pkg::acc_t SAT_HI =
        fir_pkg::acc_t'((64'sd1 <<< (fir_pkg::SAMPLE_BITS - 1)) - 64'sd1);
    localparam fir_pkg::acc_t SAT_LO = -SAT_HI - fir_pkg::acc_t'(1);

    fir_pkg::prod_t    prod_reg;
    fir_pkg::mac_ctl_t pctl_reg;
    fir_pkg::acc_t     acc_reg;
    logic              done_reg;

    fir_pkg::acc_t rnd;
    fir_pkg::acc_t shf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pctl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pctl_reg <= ctl;
            done_reg <= pctl_reg.valid & pctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * data;
        if (pctl_reg.valid)
        begin
            if (pctl_reg.first)
            begin
                acc_reg <= fir_pkg::acc_t'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + fir_pkg::acc_t'(prod_reg);
            end
        end
    end

    // round to nearest, ties up, then clamp to the sample range
    always_comb
    begin
        rnd = acc_reg + ROUND_HALF;
        shf = rnd >>> fir_pkg::FRAC_BITS;
        if (shf > SAT_HI)
        begin
            result = fir_pkg::sample_t'(SAT_HI);
        end
        else if (shf < SAT_LO)
        begin
            result = fir_pkg::sample_t'(SAT_LO);
        end
        else
        begin
            result = fir_pkg::sample_t'(shf);
        end
    end

    assign done = done_reg;

endmodule

FILE: test/fir_result_checker.sv
// Result checker for the direct-form FIR filter: keeps its own filter state,
// predicts each filtered sample and compares it with what the block delivers.
// Depends on fir_pkg and the channel interfaces in fir_if.
`timescale 1ns / 100ps

module fir_result_checker (
    input  logic clk,
    input  logic rst_n,
    fir_in_if    in_mon,
    fir_out_if   out_mon,
    output int   mismatches,
    output int   outstanding
);

    fir_pkg::sample_t coef      [fir_pkg::TAPS];
    fir_pkg::sample_t history   [fir_pkg::TAPS];
    int               head;
    fir_pkg::sample_t expected_outputs[$];
    int               result_count;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Push one sample into the delay line and return the rounded, clamped sum.
    // Products are exact and 64 taps cannot reach the 64-bit bounds.
    function automatic fir_pkg::sample_t filter_next(input fir_pkg::sample_t x);
        longint acc;
        longint hi;
        longint lo;
        head          = (head + 1) % fir_pkg::TAPS;
        history[head] = x;
        acc           = 0;
        for (int k = 0; k < fir_pkg::TAPS; k++)
        begin
            acc += longint'(coef[k]) *
                   longint'(history[(head + fir_pkg::TAPS - k) % fir_pkg::TAPS]);
        end
        acc = acc + (longint'(1) <<< (fir_pkg::FRAC_BITS - 1));
        acc = acc >>> fir_pkg::FRAC_BITS;
        hi  = (longint'(1) <<< (fir_pkg::SAMPLE_BITS - 1)) - 1;
        lo  = -hi - 1;
        if (acc > hi)
            acc = hi;
        if (acc < lo)
            acc = lo;
        return fir_pkg::sample_t'(acc);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fir_pkg::sample_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < fir_pkg::TAPS; i++)
            begin
                coef[i]    = '0;
                history[i] = '0;
            end
            head = 0;
            expected_outputs.delete();
            result_count = 0;
            mismatches   = 0;
            outstanding  <= 0;
        end
        else
        begin
            // a result can never belong to the item taken at the same edge
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_outputs.size() == 0)
                    flag_mismatch($sformatf("result %0d arrived with nothing pending",
                                            out_mon.filtered_sample));
                else
                begin
                    want = expected_outputs.pop_front();
                    if (out_mon.filtered_sample !== want)
                        flag_mismatch($sformatf("result %0d: filtered_sample %0d, want %0d",
                                                result_count, out_mon.filtered_sample, want));
                end
                result_count++;
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.kind == fir_pkg::KIND_COEF)
                begin
                    if (int'(in_mon.tap_index) < fir_pkg::TAPS)
                        coef[in_mon.tap_index] = in_mon.tap_value;
                end
                else
                    expected_outputs.push_back(filter_next(in_mon.sample_in));
            end
            outstanding <= expected_outputs.size();
        end
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the direct-form FIR filter: clock, reset, item stimulus
// and verdict. Depends on fir_pkg, fir_if, the filter RTL and fir_result_checker.
`timescale 1ns / 100ps

module tb_top;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    bit   quiet;        // set while both sides run without idling

    fir_in_if  in_ch();
    fir_out_if out_ch();

    fir_filter_direct_form u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    fir_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: ready is low on about 16 percent of cycles, never while quiet.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    // Hard stop, well above the slowest legal run (about 1850 items plus
    // stalls on both sides).
    initial
    begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    // Drive one item from a falling edge and hold it until taken.
    // valid is left high so back-to-back items need no second assignment.
    task automatic send(input logic kind, input fir_pkg::sample_t smp,
                        input fir_pkg::tap_index_t idx, input fir_pkg::sample_t val);
        while (!quiet && $urandom_range(99) < 16)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.sample_in <= smp;
        in_ch.tap_index <= idx;
        in_ch.tap_value <= val;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // unused fields carry random noise
    task automatic load_tap(input int idx, input fir_pkg::sample_t val);
        send(fir_pkg::KIND_COEF, fir_pkg::sample_t'($urandom),
             fir_pkg::tap_index_t'(idx), val);
    endtask

    task automatic push_sample(input fir_pkg::sample_t x);
        send(fir_pkg::KIND_SAMPLE, x, fir_pkg::tap_index_t'($urandom),
             fir_pkg::sample_t'($urandom));
    endtask

    // Samples: mostly full range, with extremes and values near zero.
    function automatic fir_pkg::sample_t pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return fir_pkg::sample_t'($urandom_range(8)) - 16'sd4;
            default: return fir_pkg::sample_t'($urandom);
        endcase
    endfunction

    initial
    begin
        int                 shift;
        int                 item_no;
        fir_pkg::sample_t   raw;

        // all inputs known from time zero
        rst_n           = 1'b0;
        quiet           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = fir_pkg::KIND_SAMPLE;
        in_ch.sample_in = '0;
        in_ch.tap_index = '0;
        in_ch.tap_value = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every tap gets written before the first sample: unwritten taps are
        // undefined in the block. Tap 0 = 0.5, the rest zero.
        load_tap(0, 16'sd16384);
        for (int i = 1; i < fir_pkg::TAPS; i++)
            load_tap(i, 16'sd0);

        // Rounding ties go toward plus infinity: 0.5, -0.5, 1.5, -1.5 LSB.
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd3);
        push_sample(-16'sd3);

        // Two taps at -1.0: same-sign extremes clamp high, opposite clamp low.
        load_tap(0, 16'sh8000);
        load_tap(1, 16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);

        // Two taps at full positive scale.
        load_tap(0, 16'sh7fff);
        load_tap(1, 16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sd0);

        // oldest tap, so the far end of the delay line matters
        load_tap(fir_pkg::TAPS - 1, -16'sd1);
        push_sample(16'sd0);

        // Random phases. Each reloads every tap at one magnitude, so some
        // phases stay in range and others clamp, then mixes samples with
        // occasional tap rewrites at the same magnitude.
        item_no = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(3))
                0:       shift = 0;
                1:       shift = 3;
                2:       shift = 6;
                default: shift = 9;
            endcase
            for (int i = 0; i < fir_pkg::TAPS; i++)
            begin
                raw = fir_pkg::sample_t'($urandom);
                load_tap(i, raw >>> shift);
                item_no++;
            end
            for (int n = 0; n < 157; n++)
            begin
                quiet = (item_no >= 700 && item_no < 1000);
                if ($urandom_range(9) == 0)
                begin
                    raw = fir_pkg::sample_t'($urandom);
                    load_tap($urandom_range(fir_pkg::TAPS - 1), raw >>> shift);
                end
                else
                    push_sample(pick_sample());
                item_no++;
            end
        end
        quiet = 1'b0;
        in_ch.valid <= 1'b0;

        // drain, then let any late result surface
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: fir_filter_direct_form.f
rtl/core/fir_pkg.sv
rtl/core/fir_if.sv
rtl/core/fir_ram.sv
rtl/core/fir_mac.sv
rtl/core/fir_filter_direct_form.sv
test/fir_result_checker.sv
test/tb_top.sv
